// File: rtl/core/cross_stencil_star_detect_defines.svh
// Assertion macros shared by the star detector RTL
`ifndef CROSS_STENCIL_STAR_DETECT_DEFINES_SVH
`define CROSS_STENCIL_STAR_DETECT_DEFINES_SVH

// Same-cycle implication, checked outside reset
`define CSD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset
`define CSD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/csd_pkg.sv
// Package: constants and types of the cross stencil star detector
package csd_pkg;

    // Default build sizes
    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int MAX_HEIGHT_DEF = 1024;
    localparam int PIXEL_BITS_DEF = 8;

    // Fixed field widths
    localparam int CFG_BITS   = 11;
    localparam int COORD_BITS = 10;
    localparam int CFG_IDX_BITS = 2;

    // Smallest legal image side
    localparam int MIN_SIZE = 3;

    // Register reset values
    localparam logic [CFG_BITS-1:0] IMAGE_WIDTH_RST    = 11'd15;
    localparam logic [CFG_BITS-1:0] IMAGE_HEIGHT_RST   = 11'd15;
    localparam logic [CFG_BITS-1:0] STAR_THRESHOLD_RST = 11'd30;

    // Register indexes on the configuration port
    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_IMAGE_WIDTH    = 2'd0,
        CFG_IMAGE_HEIGHT   = 2'd1,
        CFG_STAR_THRESHOLD = 2'd2
    } cfg_index_t;

    // Control carried with a pixel from the input stage to the sum stage
    typedef struct packed {
        logic emit;     // beat produces a result
        logic calc;     // interior pixel, cross sum is evaluated
        logic buf_sel;  // which line buffer holds the previous row
        logic last;     // last result of the image
    } s1_ctrl_t;

endpackage

// File: rtl/core/cross_stencil_star_detect.sv
// Top level: five-point cross star detector on a raster pixel stream
//
// Pixels enter in raster order, one per clock when the result side keeps up.
// For every pixel of row r (r >= 1) the block returns one result for the
// pixel directly above it, (r-1, c): star_flag is 1 when that pixel plus its
// four orthogonal neighbors sums to more than star_threshold; border pixels
// always give 0. The last row of the image produces no results; frame_last
// marks the final result of an image. Throughput is one pixel per clock while
// the result side keeps up. An accepted beat loads the pixel and both line
// buffer reads (two single-write, dual-read memories of MAX_WIDTH entries,
// swapped at each row end) into the input stage; the cross sum and compare
// result go to the result register when that stage fires. The line buffers
// hold no defined contents after reset and need no clearing pass. Image size
// and threshold are to be written by the user through the configuration port
// only while no pixels are in flight; the block does not enforce this. Sizes
// are clamped to [3, MAX_WIDTH] and [3, MAX_HEIGHT].
`include "cross_stencil_star_detect_defines.svh"

module cross_stencil_star_detect #(
    parameter int MAX_WIDTH  = csd_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = csd_pkg::MAX_HEIGHT_DEF,
    parameter int PIXEL_BITS = csd_pkg::PIXEL_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // configuration
    input  logic                               cfg_write,
    input  logic [csd_pkg::CFG_IDX_BITS-1:0]   cfg_index,
    input  logic [csd_pkg::CFG_BITS-1:0]       cfg_data,
    // pixel input
    input  logic                               pixel_valid,
    output logic                               pixel_ready,
    input  logic [PIXEL_BITS-1:0]              pixel_value,
    // result output
    output logic                               result_valid,
    input  logic                               result_ready,
    output logic                               star_flag,
    output logic [csd_pkg::COORD_BITS-1:0]     out_row,
    output logic [csd_pkg::COORD_BITS-1:0]     out_column,
    output logic                               frame_last
);

    localparam int CFG_W   = csd_pkg::CFG_BITS;
    localparam int COORD_W = csd_pkg::COORD_BITS;
    localparam int CW      = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int RW      = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int WV_W    = $clog2(MAX_WIDTH + 1);
    localparam int HV_W    = $clog2(MAX_HEIGHT + 1);
    localparam int SZ_A    = (WV_W > HV_W) ? WV_W : HV_W;
    localparam int SZ_W    = (SZ_A > CFG_W) ? SZ_A : CFG_W;
    localparam int SUM_W   = PIXEL_BITS + 3;
    localparam int CMP_W   = (SUM_W > CFG_W) ? SUM_W : CFG_W;

    // Configuration registers
    logic [CFG_W-1:0] image_width_reg;
    logic [CFG_W-1:0] image_height_reg;
    logic [CFG_W-1:0] star_threshold_reg;

    // Raster position and line buffer select
    logic [CW-1:0] col_reg;
    logic [RW-1:0] row_reg;
    logic          sel_reg;
    logic [CW-1:0] col_next;
    logic [RW-1:0] row_next;
    logic          sel_next;

    // Sum stage
    logic                  s1_valid_reg;
    csd_pkg::s1_ctrl_t     s1_ctrl_reg;
    csd_pkg::s1_ctrl_t     s1_ctrl_next;
    logic [PIXEL_BITS-1:0] s1_pix_reg;
    logic [COORD_W-1:0]    s1_row_reg;
    logic [COORD_W-1:0]    s1_col_reg;
    logic [PIXEL_BITS-1:0] rd_a_reg [2];
    logic [PIXEL_BITS-1:0] rd_b_reg [2];
    logic [PIXEL_BITS-1:0] win_left_reg;

    // Result register
    logic               result_valid_reg;
    logic               star_flag_reg;
    logic [COORD_W-1:0] out_row_reg;
    logic [COORD_W-1:0] out_column_reg;
    logic               frame_last_reg;

    // Handshake
    logic pixel_accept;
    logic out_free;
    logic s1_fire;

    // Position decode
    logic [SZ_W-1:0] width_val;
    logic [SZ_W-1:0] height_val;
    logic [SZ_W-1:0] col_ext;
    logic [SZ_W-1:0] row_ext;
    logic            last_col;
    logic            last_row;
    logic [RW-1:0]   row_minus;
    logic [CW-1:0]   addr_a;

    // Cross sum
    logic [PIXEL_BITS-1:0] px_left;
    logic [PIXEL_BITS-1:0] px_mid;
    logic [PIXEL_BITS-1:0] px_right;
    logic [PIXEL_BITS-1:0] px_up;
    logic [SUM_W-1:0]      cross_sum;
    logic                  flag_calc;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg    <= csd_pkg::IMAGE_WIDTH_RST;
            image_height_reg   <= csd_pkg::IMAGE_HEIGHT_RST;
            star_threshold_reg <= csd_pkg::STAR_THRESHOLD_RST;
        end
        else if (cfg_write)
        begin
            unique case (csd_pkg::cfg_index_t'(cfg_index))
                csd_pkg::CFG_IMAGE_WIDTH:    image_width_reg    <= cfg_data;
                csd_pkg::CFG_IMAGE_HEIGHT:   image_height_reg   <= cfg_data;
                csd_pkg::CFG_STAR_THRESHOLD: star_threshold_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Clamp image size into the legal range
    always_comb
    begin
        if (SZ_W'(image_width_reg) < SZ_W'(csd_pkg::MIN_SIZE))
            width_val = SZ_W'(csd_pkg::MIN_SIZE);
        else if (SZ_W'(image_width_reg) > SZ_W'(MAX_WIDTH))
            width_val = SZ_W'(MAX_WIDTH);
        else
            width_val = SZ_W'(image_width_reg);

        if (SZ_W'(image_height_reg) < SZ_W'(csd_pkg::MIN_SIZE))
            height_val = SZ_W'(csd_pkg::MIN_SIZE);
        else if (SZ_W'(image_height_reg) > SZ_W'(MAX_HEIGHT))
            height_val = SZ_W'(MAX_HEIGHT);
        else
            height_val = SZ_W'(image_height_reg);
    end

    // Decode the position of the incoming pixel
    assign col_ext   = SZ_W'(col_reg);
    assign row_ext   = SZ_W'(row_reg);
    assign last_col  = (col_ext >= width_val - SZ_W'(1));
    assign last_row  = (row_ext >= height_val - SZ_W'(1));
    assign row_minus = row_reg - RW'(1);
    assign addr_a    = col_reg + CW'(1);

    always_comb
    begin
        s1_ctrl_next.emit    = (row_reg != '0) && (row_ext <= height_val - SZ_W'(1));
        s1_ctrl_next.calc    = (row_ext >= SZ_W'(2)) && (col_reg != '0)
                               && (col_ext + SZ_W'(1) < width_val);
        s1_ctrl_next.buf_sel = sel_reg;
        s1_ctrl_next.last    = last_row && last_col;
    end

    // Raster counters advance
    always_comb
    begin
        col_next = col_reg + CW'(1);
        row_next = row_reg;
        sel_next = sel_reg;
        if (last_col)
        begin
            col_next = '0;
            sel_next = ~sel_reg;
            row_next = last_row ? '0 : row_reg + RW'(1);
        end
    end

    // Handshake between input, sum stage and result register
    assign out_free     = !result_valid_reg || result_ready;
    assign s1_fire      = s1_valid_reg && (!s1_ctrl_reg.emit || out_free);
    assign pixel_ready  = !s1_valid_reg || s1_fire;
    assign pixel_accept = pixel_valid && pixel_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
            sel_reg <= 1'b0;
        end
        else if (pixel_accept)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
            sel_reg <= sel_next;
        end
    end

    // Line buffers: the incoming pixel overwrites the older row; reads at c and c+1
    for (genvar k = 0; k < 2; k++)
    begin : g_line
        logic [PIXEL_BITS-1:0] line_mem [MAX_WIDTH];

        always_ff @(posedge clk)
        begin
            if (pixel_accept)
            begin
                if (sel_reg != 1'(k))
                    line_mem[col_reg] <= pixel_value;
                rd_a_reg[k] <= line_mem[addr_a];
                rd_b_reg[k] <= line_mem[col_reg];
            end
        end
    end

    // Sum stage control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s1_ctrl_reg  <= '0;
            win_left_reg <= '0;
        end
        else
        begin
            if (pixel_accept)
            begin
                s1_valid_reg <= 1'b1;
                s1_ctrl_reg  <= s1_ctrl_next;
            end
            else if (s1_fire)
            begin
                s1_valid_reg <= 1'b0;
            end
            // window slides by one column per beat
            if (s1_fire)
                win_left_reg <= px_mid;
        end
    end

    // Sum stage payload
    always_ff @(posedge clk)
    begin
        if (pixel_accept)
        begin
            s1_pix_reg <= pixel_value;
            s1_row_reg <= COORD_W'(row_minus);
            s1_col_reg <= COORD_W'(col_reg);
        end
    end

    // Cross sum and threshold compare
    always_comb
    begin
        px_mid    = s1_ctrl_reg.buf_sel ? rd_b_reg[1] : rd_b_reg[0];
        px_right  = s1_ctrl_reg.buf_sel ? rd_a_reg[1] : rd_a_reg[0];
        px_up     = s1_ctrl_reg.buf_sel ? rd_b_reg[0] : rd_b_reg[1];
        px_left   = win_left_reg;
        cross_sum = SUM_W'(px_left) + SUM_W'(px_mid) + SUM_W'(px_right)
                    + SUM_W'(px_up) + SUM_W'(s1_pix_reg);
        flag_calc = s1_ctrl_reg.calc && (CMP_W'(cross_sum) > CMP_W'(star_threshold_reg));
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_valid_reg <= 1'b0;
        else if (s1_fire && s1_ctrl_reg.emit)
            result_valid_reg <= 1'b1;
        else if (result_ready)
            result_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire && s1_ctrl_reg.emit)
        begin
            star_flag_reg  <= flag_calc;
            out_row_reg    <= s1_row_reg;
            out_column_reg <= s1_col_reg;
            frame_last_reg <= s1_ctrl_reg.last;
        end
    end

    assign result_valid = result_valid_reg;
    assign star_flag    = star_flag_reg;
    assign out_row      = out_row_reg;
    assign out_column   = out_column_reg;
    assign frame_last   = frame_last_reg;

    // Checks
    `CSD_ASSERT_NEXT(a_col_step, clk, rst_n, pixel_accept && !last_col,
        col_reg == $past(col_reg) + CW'(1), "column counter did not step")
    `CSD_ASSERT_NEXT(a_buf_swap, clk, rst_n, pixel_accept && last_col,
        sel_reg != $past(sel_reg), "line buffers not swapped at row end")
    `CSD_ASSERT_NEXT(a_border_zero, clk, rst_n,
        s1_fire && s1_ctrl_reg.emit && !s1_ctrl_reg.calc,
        !star_flag_reg, "star flagged on a border pixel")
    `CSD_ASSERT_NOW(a_last_border, clk, rst_n, result_valid_reg && frame_last_reg,
        !star_flag_reg, "last result of image carries a star")

endmodule

// File: tb/tb_cross_stencil_star_detect.sv
// Testbench for the five-point cross star detector: directed table, then random frames
module tb_cross_stencil_star_detect;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 2000;   // cycles with no beat on either side
    localparam int SETTLE      = 4;      // cycles after the last result before a write

    // one result beat as the block should send it
    typedef struct {
        bit                                 has;
        logic                               flag;
        logic [csd_pkg::COORD_BITS-1:0]     row;
        logic [csd_pkg::COORD_BITS-1:0]     col;
        logic                               last;
    } star_res_t;

    // directed stimulus: register write or pixel with its result typed in
    typedef struct {
        bit                                 is_cfg;
        csd_pkg::cfg_index_t                reg_idx;
        logic [csd_pkg::CFG_BITS-1:0]       reg_val;
        logic [csd_pkg::PIXEL_BITS_DEF-1:0] pix;
        star_res_t                          want;
    } stim_row_t;

    logic                                 clk = 1'b0;
    logic                                 rst_n;
    logic                                 cfg_write;
    logic [csd_pkg::CFG_IDX_BITS-1:0]     cfg_index;
    logic [csd_pkg::CFG_BITS-1:0]         cfg_data;
    logic                                 pixel_valid;
    logic                                 pixel_ready;
    logic [csd_pkg::PIXEL_BITS_DEF-1:0]   pixel_value;
    logic                                 result_valid;
    logic                                 result_ready = 1'b0;
    logic                                 star_flag;
    logic [csd_pkg::COORD_BITS-1:0]       out_row;
    logic [csd_pkg::COORD_BITS-1:0]       out_column;
    logic                                 frame_last;

    // predictor copy of registers and line memory
    logic [csd_pkg::CFG_BITS-1:0]         reg_width;
    logic [csd_pkg::CFG_BITS-1:0]         reg_height;
    logic [csd_pkg::CFG_BITS-1:0]         reg_thresh;
    bit   [csd_pkg::PIXEL_BITS_DEF-1:0]   row_mem [2][csd_pkg::MAX_WIDTH_DEF];
    int                                   row_cnt;
    int                                   col_cnt;
    bit                                   swap_sel;

    star_res_t                            awaited_flags [$];
    star_res_t                            head_flag;
    star_res_t                            no_flag = '{1'b0, 1'b0, 10'd0, 10'd0, 1'b0};

    bit                                   calm;
    int                                   stall_cycles = 0;
    int                                   mism_count;
    int                                   px_accepted;
    int                                   flags_checked;
    int                                   stars_seen;
    int                                   cfg_writes;
    int                                   small_items;
    int                                   burst;

    // two 3x3 frames: all-bright just over the top threshold, all-dark at threshold 0
    stim_row_t dir_tab [22] = '{
        '{1'b1, csd_pkg::CFG_IMAGE_WIDTH,    11'd0,    8'd0,   '{1'b0, 1'b0, 10'd0, 10'd0, 1'b0}},
        '{1'b1, csd_pkg::CFG_IMAGE_HEIGHT,   11'd1,    8'd0,   '{1'b0, 1'b0, 10'd0, 10'd0, 1'b0}},
        '{1'b1, csd_pkg::CFG_STAR_THRESHOLD, 11'd1274, 8'd0,   '{1'b0, 1'b0, 10'd0, 10'd0, 1'b0}},
        '{1'b0, csd_pkg::CFG_IMAGE_WIDTH,    11'd0,    8'd255, '{1'b0, 1'b0, 10'd0, 10'd0, 1'b0}},
        '{1'b0, csd_pkg::CFG_IMAGE_WIDTH,    11'd0,    8'd255, '{1'b0, 1'b0, 10'd0, 10'd0, 1'b0}},
        '{1'b0, csd_pkg::CFG_IMAGE_WIDTH,    11'd0,    8'd255, '{1'b0, 1'b0, 10'd0, 10'd0, 1'b0}},
        '{1'b0, csd_pkg::CFG_IMAGE_WIDTH,    11'd0,    8'd255, '{1'b1, 1'b0, 10'd0, 10'd0, 1'b0}},
        '{1'b0, csd_pkg::CFG_IMAGE_WIDTH,    11'd0,    8'd255, '{1'b1, 1'b0, 10'd0, 10'd1, 1'b0}},
        '{1'b0, csd_pkg::CFG_IMAGE_WIDTH,    11'd0,    8'd255, '{1'b1, 1'b0, 10'd0, 10'd2, 1'b0}},
        '{1'b0, csd_pkg::CFG_IMAGE_WIDTH,    11'd0,    8'd255, '{1'b1, 1'b0, 10'd1, 10'd0, 1'b0}},
        '{1'b0, csd_pkg::CFG_IMAGE_WIDTH,    11'd0,    8'd255, '{1'b1, 1'b1, 10'd1, 10'd1, 1'b0}},
        '{1'b0, csd_pkg::CFG_IMAGE_WIDTH,    11'd0,    8'd255, '{1'b1, 1'b0, 10'd1, 10'd2, 1'b1}},
        '{1'b1, csd_pkg::CFG_STAR_THRESHOLD, 11'd0,    8'd0,   '{1'b0, 1'b0, 10'd0, 10'd0, 1'b0}},
        '{1'b0, csd_pkg::CFG_IMAGE_WIDTH,    11'd0,    8'd0,   '{1'b0, 1'b0, 10'd0, 10'd0, 1'b0}},
        '{1'b0, csd_pkg::CFG_IMAGE_WIDTH,    11'd0,    8'd0,   '{1'b0, 1'b0, 10'd0, 10'd0, 1'b0}},
        '{1'b0, csd_pkg::CFG_IMAGE_WIDTH,    11'd0,    8'd0,   '{1'b0, 1'b0, 10'd0, 10'd0, 1'b0}},
        '{1'b0, csd_pkg::CFG_IMAGE_WIDTH,    11'd0,    8'd0,   '{1'b1, 1'b0, 10'd0, 10'd0, 1'b0}},
        '{1'b0, csd_pkg::CFG_IMAGE_WIDTH,    11'd0,    8'd0,   '{1'b1, 1'b0, 10'd0, 10'd1, 1'b0}},
        '{1'b0, csd_pkg::CFG_IMAGE_WIDTH,    11'd0,    8'd0,   '{1'b1, 1'b0, 10'd0, 10'd2, 1'b0}},
        '{1'b0, csd_pkg::CFG_IMAGE_WIDTH,    11'd0,    8'd0,   '{1'b1, 1'b0, 10'd1, 10'd0, 1'b0}},
        '{1'b0, csd_pkg::CFG_IMAGE_WIDTH,    11'd0,    8'd0,   '{1'b1, 1'b0, 10'd1, 10'd1, 1'b0}},
        '{1'b0, csd_pkg::CFG_IMAGE_WIDTH,    11'd0,    8'd0,   '{1'b1, 1'b0, 10'd1, 10'd2, 1'b1}}
    };

    cross_stencil_star_detect u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .pixel_valid  (pixel_valid),
        .pixel_ready  (pixel_ready),
        .pixel_value  (pixel_value),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .star_flag    (star_flag),
        .out_row      (out_row),
        .out_column   (out_column),
        .frame_last   (frame_last)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // size register as the block sees it
    function automatic int side_clamp(input logic [csd_pkg::CFG_BITS-1:0] v, input int hi);
        if (int'(v) < csd_pkg::MIN_SIZE)
            return csd_pkg::MIN_SIZE;
        if (int'(v) > hi)
            return hi;
        return int'(v);
    endfunction

    // flag for the pixel above the incoming one; advances counters and line memory
    function automatic star_res_t predict_cross_flag(
        input logic [csd_pkg::PIXEL_BITS_DEF-1:0] pix);
        star_res_t res;
        int        w;
        int        h;
        int        r;
        int        c;
        int        sum;
        bit        sel;
        bit        last_col;
        bit        last_row;
        w = side_clamp(reg_width, csd_pkg::MAX_WIDTH_DEF);
        h = side_clamp(reg_height, csd_pkg::MAX_HEIGHT_DEF);
        r = row_cnt;
        c = col_cnt;
        sel = swap_sel;
        last_col = (c >= w - 1);
        last_row = (r >= h - 1);
        res = no_flag;
        if (r >= 1 && r <= h - 1)
        begin
            res.has = 1'b1;
            // interior pixel: left, center, right of previous row, above it, below it
            if (r >= 2 && c >= 1 && c + 1 < w)
            begin
                sum = int'(row_mem[sel][c-1]) + int'(row_mem[sel][c])
                    + int'(row_mem[sel][c+1]) + int'(row_mem[!sel][c]) + int'(pix);
                res.flag = (sum > int'(reg_thresh));
            end
            res.row  = 10'(r - 1);
            res.col  = 10'(c);
            res.last = last_row && last_col;
        end
        if (c < csd_pkg::MAX_WIDTH_DEF)
            row_mem[!sel][c] = pix;
        if (last_col)
        begin
            col_cnt  = 0;
            swap_sel = !sel;
            row_cnt  = last_row ? 0 : r + 1;
        end
        else
            col_cnt = c + 1;
        return res;
    endfunction

    // pixels left until the current frame wraps
    function automatic int px_to_frame_end();
        int w;
        int h;
        int n;
        w = side_clamp(reg_width, csd_pkg::MAX_WIDTH_DEF);
        h = side_clamp(reg_height, csd_pkg::MAX_HEIGHT_DEF);
        n = (col_cnt >= w - 1) ? 1 : w - col_cnt;
        if (row_cnt < h - 1)
            n += (h - 1 - row_cnt) * w;
        return n;
    endfunction

    function automatic logic [csd_pkg::PIXEL_BITS_DEF-1:0] rand_pixel();
        int p;
        p = int'($urandom_range(99));
        if (p < 10)
            return 8'd0;
        if (p < 20)
            return 8'd255;
        return 8'($urandom_range(255));
    endfunction

    function automatic logic [csd_pkg::CFG_BITS-1:0] rand_thr();
        int p;
        p = int'($urandom_range(99));
        if (p < 10)
            return 11'd0;
        if (p < 20)
            return 11'd1275;
        if (p < 25)
            return 11'd2047;
        return 11'($urandom_range(200, 1100));
    endfunction

    // small sides only; a few below the minimum to hit saturation
    function automatic logic [csd_pkg::CFG_BITS-1:0] rand_side();
        int p;
        p = int'($urandom_range(99));
        if (p < 12)
            return 11'($urandom_range(2));
        return 11'($urandom_range(3, 10));
    endfunction

    // register write once no result is pending and the pipe has settled
    task automatic write_reg(input csd_pkg::cfg_index_t idx,
                             input logic [csd_pkg::CFG_BITS-1:0] val);
        pixel_valid <= 1'b0;
        while (awaited_flags.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_write <= 1'b0;
        case (idx)
            csd_pkg::CFG_IMAGE_WIDTH:    reg_width  = val;
            csd_pkg::CFG_IMAGE_HEIGHT:   reg_height = val;
            csd_pkg::CFG_STAR_THRESHOLD: reg_thresh = val;
            default: ;
        endcase
        cfg_writes++;
    endtask

    // one pixel beat; valid stays up after acceptance unless an idle gap follows
    task automatic send_pixel(input logic [csd_pkg::PIXEL_BITS_DEF-1:0] pix,
                              input bit use_typed, input star_res_t typed_want);
        star_res_t pred;
        if (!calm && $urandom_range(99) < 13)
        begin
            pixel_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        pixel_valid <= 1'b1;
        pixel_value <= pix;
        @(posedge clk);
        while (!pixel_ready)
            @(posedge clk);
        pred = predict_cross_flag(pix);
        if (use_typed)
            pred = typed_want;
        if (pred.has)
            awaited_flags.push_back(pred);
        px_accepted++;
    endtask

    task automatic send_random(input int n);
        repeat (n) send_pixel(rand_pixel(), 1'b0, no_flag);
    endtask

    task automatic compare_field(input string fname, input logic [9:0] want,
                                 input logic [9:0] got);
        if (got !== want)
        begin
            mism_count++;
            $display("%0t ns: %s expected %0d, got %0d", $time, fname, want, got);
        end
    endtask

    // result side: random stalls except in calm stretches
    always @(posedge clk)
        result_ready <= calm || ($urandom_range(99) >= 13);

    // compare each result beat with the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && result_valid && result_ready)
        begin
            if (awaited_flags.size() == 0)
            begin
                mism_count++;
                $display("%0t ns: expected no result, got flag %0b row %0d column %0d",
                         $time, star_flag, out_row, out_column);
            end
            else
            begin
                head_flag = awaited_flags.pop_front();
                compare_field("star_flag", 10'(head_flag.flag), 10'(star_flag));
                compare_field("out_row", head_flag.row, out_row);
                compare_field("out_column", head_flag.col, out_column);
                compare_field("frame_last", 10'(head_flag.last), 10'(frame_last));
            end
            flags_checked++;
            if (star_flag === 1'b1)
                stars_seen++;
        end
    end

    // watchdog on cycles with no beat on either side
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((pixel_valid && pixel_ready) || (result_valid && result_ready))
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("%0t ns: no beat for %0d cycles", $time, stall_cycles);
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n        <= 1'b0;
        cfg_write    <= 1'b0;
        cfg_index    <= csd_pkg::CFG_IMAGE_WIDTH;
        cfg_data     <= '0;
        pixel_valid  <= 1'b0;
        pixel_value  <= '0;
        calm         <= 1'b0;
        reg_width    = csd_pkg::IMAGE_WIDTH_RST;
        reg_height   = csd_pkg::IMAGE_HEIGHT_RST;
        reg_thresh   = csd_pkg::STAR_THRESHOLD_RST;
        row_cnt      = 0;
        col_cnt      = 0;
        swap_sel     = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // directed frames with typed results
        foreach (dir_tab[i])
        begin
            if (dir_tab[i].is_cfg)
                write_reg(dir_tab[i].reg_idx, dir_tab[i].reg_val);
            else
                send_pixel(dir_tab[i].pix, 1'b1, dir_tab[i].want);
        end

        // whole 10-wide frame, no idling: writes both line memories over every
        // column that the small frames below can reach
        write_reg(csd_pkg::CFG_IMAGE_WIDTH, 11'd10);
        write_reg(csd_pkg::CFG_IMAGE_HEIGHT, 11'd3);
        write_reg(csd_pkg::CFG_STAR_THRESHOLD, rand_thr());
        calm <= 1'b1;
        send_random(px_to_frame_end());

        // sides saturated from the top: part of a full-width row, then narrow
        // rows that run on far past a small height
        write_reg(csd_pkg::CFG_IMAGE_WIDTH, 11'd2047);
        write_reg(csd_pkg::CFG_IMAGE_HEIGHT, 11'd2047);
        send_random(40);
        write_reg(csd_pkg::CFG_IMAGE_WIDTH, 11'd3);
        send_random(40);
        write_reg(csd_pkg::CFG_IMAGE_HEIGHT, 11'd3);
        send_random(px_to_frame_end());
        calm <= 1'b0;

        // small frames; mostly whole frames, some bursts that change sizes mid-frame
        small_items = 0;
        while (small_items < 620)
        begin
            if ($urandom_range(99) < 60)
                write_reg(csd_pkg::CFG_STAR_THRESHOLD, rand_thr());
            if ($urandom_range(99) < 50)
                write_reg(csd_pkg::CFG_IMAGE_WIDTH, rand_side());
            if ($urandom_range(99) < 50)
                write_reg(csd_pkg::CFG_IMAGE_HEIGHT, rand_side());
            if ($urandom_range(99) < 75)
                burst = px_to_frame_end() + int'($urandom_range(1))
                      * side_clamp(reg_width, csd_pkg::MAX_WIDTH_DEF)
                      * side_clamp(reg_height, csd_pkg::MAX_HEIGHT_DEF);
            else
                burst = int'($urandom_range(1, 40));
            send_random(burst);
            small_items += burst;
        end

        // drain and let the pipe settle
        pixel_valid <= 1'b0;
        while (awaited_flags.size() != 0)
            @(posedge clk);
        repeat (2 * SETTLE) @(posedge clk);

        $display("Covered %0d pixel beats and %0d result beats, %0d of them stars.",
                 px_accepted, flags_checked, stars_seen);
        $display("%0d register writes: sides 0 to 2047 with saturation, thresholds 0 to 2047.",
                 cfg_writes);
        if (mism_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
